// ===== sv/pss_pkg.sv =====
// Shared types and codes for the positional sequence store.
package pss_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 5;
  localparam int unsigned LenW  = 5;
  localparam int unsigned ReadSpan = 32;  // positions reachable by a 5-bit index

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              write;
    logic [PosW-1:0]   pos;
    logic [WordW-1:0]  value;
  } cell_ctl_t;

endpackage

// ===== sv/pss_cell.sv =====
// One slot of the sequence: holds a word and trades it with its neighbors.
module pss_cell
  import pss_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [WordW-1:0] left,
  input  logic [WordW-1:0] right,
  output logic [WordW-1:0] slot
);

  localparam logic [31:0] IdxW = 32'(IDX);

  logic [31:0]      pos_ext;
  logic [WordW-1:0] slot_next;

  assign pos_ext = 32'(ctl.pos);

  always_comb begin
    slot_next = slot;
    if (ctl.shift_up) begin
      if (IdxW > pos_ext) begin
        slot_next = left;
      end else if (IdxW == pos_ext) begin
        slot_next = ctl.value;
      end
    end else if (ctl.shift_down) begin
      if (IdxW >= pos_ext) begin
        slot_next = right;
      end
    end else if (ctl.write && (IdxW == pos_ext)) begin
      slot_next = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// ===== sv/positional_sequence_store.sv =====
// Top level of the positional sequence store.
// Holds an ordered list of up to CAPACITY signed 32-bit words in a row of
// slot cells. On taking a request (insert, remove, update or read at a
// position), an insert or remove shifts the slots from the position up and
// an update writes that one slot; the result sits in an output register
// from the cycle after the request is taken. A new request is taken
// whenever that register is empty or being drained, so the block sustains
// one request per cycle; output back-pressure is the only limit. The slots
// need no clearing after reset, as only slots below the count are ever read.
module positional_sequence_store
  import pss_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero pad
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // word_out[31:0], length[36:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned MaxW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic [MaxW-1:0]  count_ext;
  logic [MaxW-1:0]  count_ext_next;
  logic [MaxW-1:0]  pos_ext;
  logic             accept;
  kind_t            kind;
  logic [PosW-1:0]  position;
  logic [WordW-1:0] value;
  status_t          status;
  logic [WordW-1:0] word;
  logic             ok;
  cell_ctl_t        ctl;

  logic [WordW-1:0] slot_q [CAPACITY];
  logic [WordW-1:0] rd     [ReadSpan];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = kind_t'(s_axis_tuser);
  assign position      = s_axis_tdata[4:0];
  assign value         = s_axis_tdata[36:5];
  assign count_ext     = MaxW'(count);
  assign pos_ext       = MaxW'(position);

  // Read port: only the first 32 positions are addressable.
  for (genvar r = 0; r < ReadSpan; r++) begin : g_rd
    if (r < CAPACITY) begin : g_slot
      assign rd[r] = slot_q[r];
    end else begin : g_none
      assign rd[r] = '0;
    end
  end

  always_comb begin
    status     = ST_OK;
    word       = '1;
    ok         = 1'b0;
    count_next = count;
    unique case (kind) inside
      KIND_INSERT: begin
        if (pos_ext > count_ext) begin
          status = ST_BADPOS;
        end else if (count == CapCnt) begin
          status = ST_FULL;
        end else begin
          ok         = 1'b1;
          count_next = count + CntW'(1);
        end
      end
      KIND_REMOVE, KIND_UPDATE, KIND_READ: begin
        if (pos_ext >= count_ext) begin
          status = ST_BADPOS;
        end else begin
          ok = 1'b1;
          if (kind == KIND_REMOVE) begin
            word       = rd[position];
            count_next = count - CntW'(1);
          end else if (kind == KIND_READ) begin
            word = rd[position];
          end
        end
      end
      default: status = ST_BADPOS;
    endcase
  end

  assign count_ext_next = MaxW'(count_next);

  always_comb begin
    ctl            = '0;
    ctl.pos        = position;
    ctl.value      = value;
    ctl.shift_up   = accept && ok && (kind == KIND_INSERT);
    ctl.shift_down = accept && ok && (kind == KIND_REMOVE);
    ctl.write      = accept && ok && (kind == KIND_UPDATE);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
    if (i == 0) begin : g_first
      assign left = value;
    end else begin : g_mid_l
      assign left = slot_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = slot_q[i];
    end else begin : g_mid_r
      assign right = slot_q[i+1];
    end
    pss_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .slot  (slot_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {3'b000, count_ext_next[LenW-1:0], word};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CapCnt)
    else $error("count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("count moved without a request");

  a_length_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[36:32] == count_ext[LenW-1:0]))
    else $error("reported length differs from count");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined status code");

endmodule

// ===== tb/positional_sequence_store_test.sv =====
// Self-checking testbench for the positional sequence store (insert/remove/update/read).
`timescale 1ns / 1ps

module positional_sequence_store_test;
  import pss_pkg::*;

  localparam int CAPACITY = 16;

  typedef struct {
    status_t     status;
    logic [31:0] word;
    logic [4:0]  length;
  } store_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Shadow copy of the store, advanced as each request is taken.
  logic [31:0]   held_words [CAPACITY];
  int            held_count = 0;
  store_result_t pending_results [$];
  int            error_count = 0;

  bit src_idling  = 1'b1;
  bit sink_idling = 1'b1;
  int sink_gap_left = 0;
  int sink_hold_left = 0;

  positional_sequence_store #(.CAPACITY(CAPACITY)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("positional_sequence_store test failed");
    $finish;
  end

  function automatic store_result_t apply_request(kind_t k, logic [4:0] pos,
                                                  logic [31:0] val);
    store_result_t r;
    int i;
    r.status = ST_OK;
    r.word   = '1;
    if (k == KIND_INSERT) begin
      if (pos > held_count) begin
        r.status = ST_BADPOS;
      end else if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (i = held_count; i > pos; i--) held_words[i] = held_words[i-1];
        held_words[pos] = val;
        held_count++;
      end
    end else if (pos >= held_count) begin
      r.status = ST_BADPOS;
    end else if (k == KIND_REMOVE) begin
      r.word = held_words[pos];
      for (i = pos; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
      held_count--;
    end else if (k == KIND_UPDATE) begin
      held_words[pos] = val;
    end else begin
      r.word = held_words[pos];
    end
    r.length = held_count[4:0];
    return r;
  endfunction

  // Results are retired before the same edge's request is predicted; the
  // block's latency keeps a request's result from leaving on its own edge.
  always @(posedge clk) begin
    store_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status %0d word %h length %0d", $time,
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata[31:0] !== want.word) begin
            $display("%0t: word_out expected %h got %h", $time, want.word,
                     m_axis_tdata[31:0]);
            error_count++;
          end
          if (m_axis_tdata[36:32] !== want.length) begin
            $display("%0t: length expected %0d got %0d", $time, want.length,
                     m_axis_tdata[36:32]);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(apply_request(kind_t'(s_axis_tuser),
                                                s_axis_tdata[4:0], s_axis_tdata[36:5]));
    end
  end

  always @(negedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_idling && sink_gap_left > 0) begin
      sink_gap_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_idling && $urandom_range(0, 9) == 0) begin
      sink_gap_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Called and returns at a falling edge; tvalid is set in place so that
  // back-to-back calls leave one final value per edge.
  task automatic send_request(kind_t k, logic [4:0] pos, logic [31:0] val);
    if (src_idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  <= {3'b000, val, pos};
    s_axis_tuser  <= k;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions so the list actually grows and shrinks.
  task automatic send_random_request(bit growing);
    kind_t       k;
    logic [4:0]  pos;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < (growing ? 55 : 20))      k = KIND_INSERT;
    else if (pick < (growing ? 70 : 60)) k = KIND_REMOVE;
    else if (pick < 80)                  k = KIND_UPDATE;
    else                                 k = KIND_READ;
    if ($urandom_range(0, 9) == 0)
      pos = 5'($urandom_range(0, 31));
    else if (k == KIND_INSERT)
      pos = 5'($urandom_range(0, held_count));
    else
      pos = (held_count == 0) ? 5'd0 : 5'($urandom_range(0, held_count - 1));
    send_request(k, pos, random_word());
  endtask

  task automatic test_edge_cases();
    send_request(KIND_READ,   5'd0,  32'h1234_5678);
    send_request(KIND_REMOVE, 5'd0,  32'h0);
    send_request(KIND_UPDATE, 5'd0,  32'hDEAD_BEEF);
    send_request(KIND_INSERT, 5'd1,  32'h1111_1111);
    send_request(KIND_INSERT, 5'd31, 32'h2222_2222);
    send_request(KIND_INSERT, 5'd0,  32'h8000_0000);
    send_request(KIND_INSERT, 5'd1,  32'h7FFF_FFFF);
    send_request(KIND_INSERT, 5'd0,  32'hFFFF_FFFF);
    send_request(KIND_INSERT, 5'd2,  32'h0000_0000);
    for (int i = 0; i < 4; i++) send_request(KIND_READ, 5'(i), 32'h0);
    send_request(KIND_UPDATE, 5'd3,  32'h5A5A_A5A5);
    send_request(KIND_READ,   5'd3,  32'h0);
    send_request(KIND_READ,   5'd4,  32'h0);
    send_request(KIND_READ,   5'd31, 32'h0);
    send_request(KIND_REMOVE, 5'd31, 32'h0);
    send_request(KIND_UPDATE, 5'd31, 32'hFFFF_FFFF);
    send_request(KIND_REMOVE, 5'd1,  32'h0);
    send_request(KIND_REMOVE, 5'd2,  32'h0);
    send_request(KIND_REMOVE, 5'd0,  32'h0);
    send_request(KIND_READ,   5'd0,  32'h0);
  endtask

  task automatic test_full_store();
    while (held_count < CAPACITY)
      send_request(KIND_INSERT, 5'($urandom_range(0, held_count)), random_word());
    send_request(KIND_INSERT, 5'd16, 32'hAAAA_AAAA);
    // position check wins over the full check
    send_request(KIND_INSERT, 5'd17, 32'h5555_5555);
    send_request(KIND_INSERT, 5'd0,  32'h8000_0000);
    send_request(KIND_READ,   5'd15, 32'h0);
    send_request(KIND_UPDATE, 5'd15, 32'h7FFF_FFFF);
    send_request(KIND_READ,   5'd15, 32'h0);
    send_request(KIND_READ,   5'd16, 32'h0);
    send_request(KIND_REMOVE, 5'd15, 32'h0);
    send_request(KIND_REMOVE, 5'd0,  32'h0);
    while (held_count > 0)
      send_request(KIND_REMOVE, 5'($urandom_range(0, held_count - 1)), 32'h0);
  endtask

  task automatic test_random_mix(int n_requests);
    bit growing;
    growing = 1'b1;
    repeat (n_requests) begin
      if (held_count >= CAPACITY) growing = 1'b0;
      else if (held_count == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = ~growing;
      send_random_request(growing);
    end
  endtask

  // Sink holds off for a long stretch while requests keep coming.
  task automatic test_output_stall();
    src_idling = 1'b0;
    @(posedge clk);
    sink_hold_left = 80;
    @(negedge clk);
    repeat (40) send_random_request(1'($urandom_range(0, 1)));
    src_idling = 1'b1;
  endtask

  task automatic test_steady_stream();
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    test_random_mix(300);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_edge_cases();
    test_full_store();
    test_random_mix(600);
    test_output_stall();
    test_random_mix(500);
    test_steady_stream();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("positional_sequence_store test passed");
    else
      $display("positional_sequence_store test failed");
    $finish;
  end

endmodule
